// ----- rtl/pev_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pev_pkg
// Shared types and constants of the postfix expression evaluator: the channel
// payloads, status codes, sequencer states and the divider request/response.
// ----------------------------------------------------------------------------
package pev_pkg;

	// sizing
	localparam int STACK_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	// result status codes
	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_UNDER = 3'd1,
		STAT_OVER  = 3'd2,
		STAT_DIVZ  = 3'd3,
		STAT_BADCH = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_RHS,
		S_RD_LHS,
		S_EXEC,
		S_DIV_WAIT,
		S_WRITE,
		S_FIN,
		S_EMIT
	} state_t;

	// channel payloads
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		status_t                       status;
	} result_t;

	// divider handshake
	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [VALUE_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- rtl/pev_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pev_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. The divisor must be nonzero; the quotient wraps at VALUE_WIDTH bits.
// ----------------------------------------------------------------------------
module pev_div import pev_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic                   neg_q;
	logic [VALUE_WIDTH:0]   shifted;
	logic [VALUE_WIDTH:0]   diff;

	// one restoring step
	always_comb begin
		shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand magnitudes and shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend[VALUE_WIDTH-1] ?
				(VALUE_WIDTH'(0) - req.dividend) : req.dividend;
			dvs_q <= req.divisor[VALUE_WIDTH-1] ?
				(VALUE_WIDTH'(0) - req.divisor) : req.divisor;
			neg_q <= req.dividend[VALUE_WIDTH-1] ^ req.divisor[VALUE_WIDTH-1];
		end else if (busy_q) begin
			rem_q <= diff[VALUE_WIDTH] ? shifted[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
		end
	end

	// sign fix on the way out
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (VALUE_WIDTH'(0) - quo_q) : quo_q;

endmodule

// ----- rtl/postfix_expression_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression fed one character per transfer, with an
// operand stack in a small memory, one shared divider and a sequencer.
//
//   channel  direction  payload    notes
//   item     in         item_t     one character, is_last marks the end
//   result   out        result_t   one per expression, on the last character
//
// A digit is decoded and pushed; + - * take two stack reads through the single
// registered read port, execute and write back; / also waits on the bit-serial
// divider between execute and write back. A last character adds an emit state.
// item_stall is high while a character is in work, which includes a last
// character whose result waits for the output register to free up.
// Reset clears the stack pointer and error status; stack contents are not
// cleared, since only values from written entries are ever used.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pev_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	state_t                 state_q, state_d;
	logic [7:0]             char_q;
	logic                   last_q;
	logic [SP_W-1:0]        sp_q;
	status_t                err_q;
	logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic [VALUE_WIDTH-1:0] lhs_q, rhs_q, res_q;
	logic                   result_valid_q;
	result_t                result_q;

	logic                   is_digit, is_op;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr, rd_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic                   err_set;
	status_t                err_code;
	logic                   sp_inc, sp_dec;
	logic                   out_load;
	status_t                fin_status;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	// character classes
	always_comb begin
		is_digit = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
		is_op    = (char_q == CH_PLUS) || (char_q == CH_MINUS) ||
			(char_q == CH_STAR) || (char_q == CH_SLASH);
	end

	// status reported at the end of an expression
	always_comb begin
		if (err_q != STAT_OK) begin
			fin_status = err_q;
		end else if (sp_q == '0) begin
			fin_status = STAT_UNDER;
		end else begin
			fin_status = STAT_OK;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer strobes
	always_comb begin
		state_d          = state_q;
		wr_en            = 1'b0;
		wr_addr          = sp_q[ADDR_W-1:0];
		wr_data          = {{(VALUE_WIDTH-4){1'b0}}, 4'(char_q - CH_ZERO)};
		rd_addr          = ADDR_W'(sp_q - SP_W'(1));
		err_set          = 1'b0;
		err_code         = STAT_OK;
		sp_inc           = 1'b0;
		sp_dec           = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = lhs_q;
		div_req.divisor  = rhs_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				if (err_q != STAT_OK) begin
					state_d = S_FIN;
				end else if (is_digit) begin
					if (sp_q == SP_W'(STACK_DEPTH)) begin
						err_set  = 1'b1;
						err_code = STAT_OVER;
					end else begin
						wr_en  = 1'b1;
						sp_inc = 1'b1;
					end
				end else if (!is_op) begin
					err_set  = 1'b1;
					err_code = STAT_BADCH;
				end else if (sp_q < SP_W'(2)) begin
					err_set  = 1'b1;
					err_code = STAT_UNDER;
				end else begin
					state_d = S_RD_RHS;
				end
			end
			S_RD_RHS: begin
				rd_addr = ADDR_W'(sp_q - SP_W'(2));
				state_d = S_RD_LHS;
			end
			S_RD_LHS: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_WRITE;
				if (char_q == CH_SLASH) begin
					if (rhs_q == '0) begin
						err_set  = 1'b1;
						err_code = STAT_DIVZ;
						state_d  = S_FIN;
					end else begin
						div_req.start = 1'b1;
						state_d       = S_DIV_WAIT;
					end
				end
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(sp_q - SP_W'(2));
				wr_data = res_q;
				sp_dec  = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers: stack pointer, sticky error, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q           <= '0;
			err_q          <= STAT_OK;
			result_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				sp_q  <= '0;
				err_q <= STAT_OK;
			end else begin
				if (sp_inc) begin
					sp_q <= sp_q + SP_W'(1);
				end else if (sp_dec) begin
					sp_q <= sp_q - SP_W'(1);
				end
				if (err_set) begin
					err_q <= err_code;
				end
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// operand stack memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			char_q <= item.char_code;
			last_q <= item.is_last;
		end
		if (state_q == S_RD_RHS) begin
			rhs_q <= rd_data_q;
		end
		if (state_q == S_RD_LHS) begin
			lhs_q <= rd_data_q;
		end
		if (state_q == S_EXEC) begin
			case (char_q)
				CH_PLUS:  res_q <= lhs_q + rhs_q;
				CH_MINUS: res_q <= lhs_q - rhs_q;
				CH_STAR:  res_q <= lhs_q * rhs_q;
				default:  res_q <= res_q;
			endcase
		end else if (state_q == S_DIV_WAIT && div_rsp.done) begin
			res_q <= div_rsp.quotient;
		end
		if (out_load) begin
			result_q.status <= fin_status;
			result_q.value  <= (fin_status == STAT_OK) ? rd_data_q : '0;
		end
	end

	// shared divider
	pev_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	// the stack pointer never passes the depth
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	// an error result always carries a zero value
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.status == STAT_OK || result_q.value == '0))
		else $error("nonzero value with error status");

	// emitting a result clears the stack pointer and error and raises the output valid
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (sp_q == '0 && err_q == STAT_OK && result_valid_q))
		else $error("state not cleared after result");

	// divider completes only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV_WAIT)
		else $error("divider done outside wait state");

	// an operator reaching execute had two operands
	a_exec_operands: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> sp_q >= SP_W'(2))
		else $error("execute with fewer than two operands");
`endif

endmodule
